FILE: rtl/osi_pkg.sv
package osi_pkg;

  localparam int SUM_W = 44;
  localparam int MAG_W = 32;
  localparam int HALF_W = 22;
  localparam int ROOT_W = 45;
  localparam int RAD_W = 90;
  localparam int LAYER_W = 10;
  localparam int STEP_W = 12;
  localparam int ID_W = 16;
  localparam int OSI_W = 16;
  localparam int DIV_STEPS = 16;
  localparam int DEFAULT_MAX_LAYERS = 1024;

  localparam logic [STEP_W-1:0] TOTAL_STEPS_RESET = 12'd4;
  localparam logic REG_TOTAL_STEPS = 1'b0;

  typedef struct packed {
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] vz;
    logic [SUM_W-1:0] vy;
    logic [SUM_W-1:0] vx;
  } entry_t;

endpackage

FILE: rtl/osi_store.sv
module osi_store #(
  parameter int DEPTH = osi_pkg::DEFAULT_MAX_LAYERS,
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output osi_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  osi_pkg::entry_t wr_data
);
  import osi_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/osi_norm.sv
module osi_norm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [osi_pkg::SUM_W-1:0]  a,
  input  logic [osi_pkg::SUM_W-1:0]  b,
  input  logic [osi_pkg::SUM_W-1:0]  c,
  output logic                       done,
  output logic [osi_pkg::ROOT_W-1:0] root
);
  import osi_pkg::*;

  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_STEPS);
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_HH = 2'd2;
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef enum logic [3:0] {
    N_IDLE  = 4'b0001,
    N_SQ    = 4'b0010,
    N_FLUSH = 4'b0100,
    N_ROOT  = 4'b1000
  } nstate_t;

  nstate_t state;
  logic [SUM_W-1:0] a_q, b_q, c_q;
  logic [1:0] comp, part, prod_part;
  logic [2*HALF_W-1:0] prod;
  logic prod_v;
  logic [RAD_W-1:0] acc, rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;

  logic [SUM_W-1:0] opnd;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [RAD_W-1:0] addend, acc_sum;
  logic [REM_W+1:0] rem_t, trial;
  logic ge;

  always_comb begin
    unique case (comp)
      COMP_X:  opnd = a_q;
      COMP_Y:  opnd = b_q;
      default: opnd = c_q;
    endcase
    mul_a = (part == PART_LL) ? opnd[HALF_W-1:0] : opnd[SUM_W-1:HALF_W];
    mul_b = (part == PART_HH) ? opnd[SUM_W-1:HALF_W] : opnd[HALF_W-1:0];
    unique case (prod_part)
      PART_LL: addend = RAD_W'(prod);
      PART_HL: addend = RAD_W'(prod) << (HALF_W + 1);
      default: addend = RAD_W'(prod) << (2 * HALF_W);
    endcase
    acc_sum = prod_v ? acc + addend : acc;
    rem_t = {rem, rad[RAD_W-1:RAD_W-2]};
    trial = {2'b00, root, 2'b01};
    ge = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            a_q <= a;
            b_q <= b;
            c_q <= c;
            comp <= COMP_X;
            part <= PART_LL;
            acc <= '0;
            prod_v <= 1'b0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          prod <= mul_a * mul_b;
          prod_part <= part;
          prod_v <= 1'b1;
          acc <= acc_sum;
          if (part == PART_HH) begin
            part <= PART_LL;
            comp <= comp + 2'd1;
            if (comp == COMP_Z) begin
              state <= N_FLUSH;
            end
          end else begin
            part <= part + 2'd1;
          end
        end
        N_FLUSH: begin
          prod_v <= 1'b0;
          rad <= acc_sum;
          rem <= '0;
          root <= '0;
          cnt <= '0;
          state <= N_ROOT;
        end
        N_ROOT: begin
          rem <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
          root <= {root[ROOT_W-2:0], ge};
          rad <= rad << 2;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
            done <= 1'b1;
            state <= N_IDLE;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/oscillatory_shear_index_unit.sv
// Oscillatory shear index accumulator for wall traction samples.
// Input stream s_*: one sample per transaction (layer, time step, element id,
// Q16.16 traction vector). Output stream m_*: one result per closed window,
// element id and Q0.16 OSI in m_tdata, undefined-ratio flag in m_tuser.
// The APB port holds total_steps at address 0, which sets the averaging
// window; write it only while the block is idle.
// After reset the block sweeps its per-layer store to zero, one entry per
// cycle, across all MAX_LAYERS entries (1024 by default) with s_tready low.
// One sample is worked at a time; s_tready is low until it is done.
// Samples outside the window return to idle after S_CHECK. A sample inside
// the window runs the shared norm unit: three partial products per component
// for the squares, a flush, then the square-root digits. At the window's last
// step, a zero magnitude sum is flagged undefined; otherwise a second norm
// pass and a 16-bit divider come before the output register takes the result.
// The output register holds a result until m_tready takes it; a later closing
// sample then waits for it in S_EMIT, and no other sample is taken meanwhile.
module oscillatory_shear_index_unit #(
  parameter int MAX_LAYERS = osi_pkg::DEFAULT_MAX_LAYERS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // layer_index, time_step, target_id, traction_x, traction_y, traction_z
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // element_id, osi_value
  output logic [31:0]  m_tdata,
  // undefined_flag
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import osi_pkg::*;

  localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_CHECK = 8'b00000100,
    S_SNORM = 8'b00001000,
    S_UPD   = 8'b00010000,
    S_VNORM = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  function automatic logic [MAG_W-1:0] abs32(input logic [MAG_W-1:0] v);
    return v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
  endfunction

  function automatic logic [SUM_W-1:0] abs44(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
  endfunction

  state_t state;
  logic [STEP_W-1:0] total_steps;
  logic [LAYER_W-1:0] layer_q;
  logic [STEP_W-1:0] step_q;
  logic [ID_W-1:0] id_q;
  logic [MAG_W-1:0] tx, ty, tz;
  logic [AW-1:0] clr_addr;
  logic [SUM_W-1:0] m_q;
  logic [ROOT_W-1:0] div_r;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [OSI_W-1:0] osi_q;
  logic flag_q;

  logic [STEP_W-3:0] quarter;
  logic [STEP_W-2:0] start_w;
  logic [STEP_W-1:0] stop_w;
  logic in_win, layer_ok, last_step;
  entry_t rd_data, wr_data, upd;
  logic wr_en;
  logic [AW-1:0] addr, wr_addr;
  logic [SUM_W:0] mag_sum;
  logic norm_start, norm_done;
  logic [SUM_W-1:0] norm_a, norm_b, norm_c;
  logic [ROOT_W-1:0] norm_root, v_cl;
  logic div_ge;
  logic [ROOT_W-1:0] div_diff;
  logic cfg_wr;
  logic emit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL_STEPS);
  assign prdata = (paddr[2] == REG_TOTAL_STEPS) ? 32'(total_steps) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps <= TOTAL_STEPS_RESET;
    end else if (cfg_wr) begin
      total_steps <= pwdata[STEP_W-1:0];
    end
  end

  assign s_tready = (state == S_IDLE);
  assign emit = (state == S_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    quarter = total_steps[STEP_W-1:2];
    start_w = {quarter, 1'b0};
    stop_w = STEP_W'(start_w) + STEP_W'(quarter);
    in_win = (step_q >= STEP_W'(start_w)) && (step_q <= stop_w);
    layer_ok = 32'(layer_q) < MAX_LAYERS;
    last_step = (step_q == stop_w);
    addr = AW'(layer_q);

    mag_sum = {1'b0, rd_data.mag} + (SUM_W + 1)'(norm_root);
    upd.vx = rd_data.vx + {{(SUM_W-MAG_W){tx[MAG_W-1]}}, tx};
    upd.vy = rd_data.vy + {{(SUM_W-MAG_W){ty[MAG_W-1]}}, ty};
    upd.vz = rd_data.vz + {{(SUM_W-MAG_W){tz[MAG_W-1]}}, tz};
    upd.mag = mag_sum[SUM_W] ? '1 : mag_sum[SUM_W-1:0];

    wr_en = (state == S_CLEAR) || (state == S_UPD);
    wr_addr = (state == S_CLEAR) ? clr_addr : addr;
    wr_data = ((state == S_CLEAR) || last_step) ? '0 : upd;

    norm_start = ((state == S_CHECK) && in_win && layer_ok) ||
                 ((state == S_UPD) && last_step && (upd.mag != '0));
    if (state == S_UPD) begin
      norm_a = abs44(upd.vx);
      norm_b = abs44(upd.vy);
      norm_c = abs44(upd.vz);
    end else begin
      norm_a = SUM_W'(abs32(tx));
      norm_b = SUM_W'(abs32(ty));
      norm_c = SUM_W'(abs32(tz));
    end

    v_cl = (norm_root > {1'b0, m_q}) ? {1'b0, m_q} : norm_root;
    div_ge = div_r >= {1'b0, m_q};
    div_diff = div_ge ? div_r - {1'b0, m_q} : div_r;
  end

  osi_store #(
    .DEPTH(MAX_LAYERS),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .rd_en(state == S_CHECK),
    .rd_addr(addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  osi_norm u_norm (
    .clk(clk),
    .rst(rst),
    .start(norm_start),
    .a(norm_a),
    .b(norm_b),
    .c(norm_c),
    .done(norm_done),
    .root(norm_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_LAYERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            layer_q <= s_tdata[9:0];
            step_q <= s_tdata[21:10];
            id_q <= s_tdata[37:22];
            tx <= s_tdata[69:38];
            ty <= s_tdata[101:70];
            tz <= s_tdata[133:102];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (in_win && layer_ok) ? S_SNORM : S_IDLE;
        end
        S_SNORM: begin
          if (norm_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          m_q <= upd.mag;
          if (!last_step) begin
            state <= S_IDLE;
          end else if (upd.mag == '0) begin
            osi_q <= '0;
            flag_q <= 1'b1;
            state <= S_EMIT;
          end else begin
            state <= S_VNORM;
          end
        end
        S_VNORM: begin
          if (norm_done) begin
            div_r <= {1'b0, m_q} - v_cl;
            div_cnt <= '0;
            flag_q <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_r <= {div_diff[ROOT_W-2:0], 1'b0};
          osi_q <= {osi_q[OSI_W-2:0], div_ge};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            m_tdata <= {osi_q, id_q};
            m_tuser <= flag_q;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
